FILE: hdl/asq_pkg.sv
// Shared types and constants for the autostart mode sequencer.
// No dependencies; compiled first.
`default_nettype none

package asq_pkg;

  localparam logic [7:0] KEEPALIVE_TICKS = 8'd200;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_STARTUP  = 3'd1,
    ST_STARTING = 3'd2,
    ST_RUNNING  = 3'd3,
    ST_LOADED   = 3'd4,
    ST_COOLDOWN = 3'd5,
    ST_ERROR    = 3'd6,
    ST_STOPPED  = 3'd7
  } as_state_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2
  } cmd_t;

  // Reported controller modes.
  localparam logic [3:0] MODE_AUTOSTARTING = 4'd0;
  localparam logic [3:0] MODE_ENG_START    = 4'd1;
  localparam logic [3:0] MODE_REV1         = 4'd2;
  localparam logic [3:0] MODE_PUMP_UP      = 4'd3;
  localparam logic [3:0] MODE_INLET_CLOSE  = 4'd4;
  localparam logic [3:0] MODE_RUN_UNLOADED = 4'd5;
  localparam logic [3:0] MODE_REV2         = 4'd6;
  localparam logic [3:0] MODE_PRE_LOADED   = 4'd7;
  localparam logic [3:0] MODE_LOADED_LO    = 4'd8;
  localparam logic [3:0] MODE_LOADED_HI    = 4'd9;
  localparam logic [3:0] MODE_DOWN         = 4'd10;
  localparam logic [3:0] MODE_OTHER        = 4'd11;

  // Configuration register indexes.
  localparam logic REG_AUTOSTOP_ENABLE = 1'b0;
  localparam logic REG_COOLDOWN_LIMIT  = 1'b1;

  typedef struct packed {
    logic        auto_enable;
    logic        start_switch;
    logic [3:0]  machine_mode;
    logic [31:0] tick_now;
    logic        sender_idle;
  } poll_t;

  typedef struct packed {
    logic [2:0]  autostart_state;
    logic        send_now;
    logic [1:0]  command_code;
    logic        red_led_set;
    logic [15:0] cooldown_elapsed;
  } result_t;

  typedef struct packed {
    logic        autostop_enable;
    logic [15:0] cooldown_limit;
  } cfg_regs_t;

endpackage

`default_nettype wire

FILE: hdl/asq_ifs.sv
// Valid/ready channel interfaces for the autostart mode sequencer.
// Depends on asq_pkg.
`default_nettype none

interface asq_poll_if;
  logic           valid;
  logic           ready;
  asq_pkg::poll_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface asq_result_if;
  logic             valid;
  logic             ready;
  asq_pkg::result_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface asq_cfg_if;
  logic        valid;
  logic        ready;
  logic        reg_index;
  logic [15:0] wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

FILE: hdl/asq_core.sv
// Sequencer state and the per-poll update: mode mapping, cooldown timing,
// command change detection and keepalive resend. Depends on asq_pkg.
`default_nettype none

module asq_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire asq_pkg::poll_t     poll,
  input  wire asq_pkg::cfg_regs_t cfg,
  output asq_pkg::result_t        res
);
  import asq_pkg::*;

  as_state_t   mode_state, mode_state_next;
  logic [31:0] entry_tick, entry_tick_next;
  cmd_t        last_command, last_command_next;
  logic [7:0]  keepalive_count, keepalive_count_next;
  logic [31:0] last_tick_seen, last_tick_seen_next;
  logic [15:0] cool_ticks, cool_ticks_next;

  as_state_t   mapped;
  cmd_t        cmd;
  logic        red;
  logic        send;
  logic [31:0] elapsed;

  always_comb begin
    mapped          = mode_state;
    entry_tick_next = entry_tick;
    cmd             = CMD_NONE;
    red             = 1'b0;
    if (!poll.auto_enable) begin
      mapped = ST_IDLE;
    end else begin
      unique case (poll.machine_mode)
        MODE_AUTOSTARTING: mapped = ST_STARTUP;
        MODE_ENG_START, MODE_REV1, MODE_PUMP_UP, MODE_INLET_CLOSE: mapped = ST_STARTING;
        MODE_RUN_UNLOADED: begin
          entry_tick_next = poll.tick_now;
          mapped          = ST_RUNNING;
        end
        MODE_REV2: mapped = ST_LOADED;
        MODE_PRE_LOADED, MODE_LOADED_LO, MODE_LOADED_HI: begin
          if (mode_state != ST_COOLDOWN) mapped = ST_LOADED;
        end
        MODE_DOWN: begin
          mapped = ST_ERROR;
          red    = 1'b1;
        end
        default: begin
          mapped = ST_STOPPED;
          if (poll.start_switch) cmd = CMD_START;
        end
      endcase
    end

    // The elapsed count uses the entry tick as updated earlier in this poll.
    elapsed         = poll.tick_now - entry_tick_next;
    mode_state_next = mapped;
    cool_ticks_next = cool_ticks;
    if (mapped == ST_LOADED) begin
      if (!poll.start_switch && cfg.autostop_enable) begin
        entry_tick_next = poll.tick_now;
        mode_state_next = ST_COOLDOWN;
      end
    end else if (mapped == ST_COOLDOWN) begin
      if (poll.start_switch) begin
        mode_state_next = ST_LOADED;
      end else begin
        cool_ticks_next = elapsed[15:0];
        if (elapsed[15:0] >= cfg.cooldown_limit) cmd = CMD_STOP;
      end
    end

    keepalive_count_next = keepalive_count;
    last_tick_seen_next  = last_tick_seen;
    last_command_next    = last_command;
    send                 = 1'b0;
    if (cmd == last_command && keepalive_count != 8'd0) begin
      if (last_tick_seen != poll.tick_now) begin
        last_tick_seen_next  = poll.tick_now;
        keepalive_count_next = keepalive_count - 8'd1;
      end
    end else if (poll.sender_idle) begin
      keepalive_count_next = KEEPALIVE_TICKS;
      last_command_next    = cmd;
      send                 = 1'b1;
    end

    res.autostart_state  = mode_state_next;
    res.send_now         = send;
    res.command_code     = send ? cmd : CMD_NONE;
    res.red_led_set      = red;
    res.cooldown_elapsed = cool_ticks_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_state      <= ST_IDLE;
      entry_tick      <= '0;
      last_command    <= CMD_NONE;
      keepalive_count <= KEEPALIVE_TICKS;
      last_tick_seen  <= '0;
      cool_ticks      <= '0;
    end else if (step) begin
      mode_state      <= mode_state_next;
      entry_tick      <= entry_tick_next;
      last_command    <= last_command_next;
      keepalive_count <= keepalive_count_next;
      last_tick_seen  <= last_tick_seen_next;
      cool_ticks      <= cool_ticks_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/autostart_mode_sequencer.sv
// Top level of the autostart mode sequencer: poll input register, result
// register and configuration registers. Depends on asq_pkg, asq_ifs, asq_core.
//
//   Channel   Direction  Transaction
//   poll      sink       one poll: switches, machine mode, tick, sender idle
//   result    source     one result per poll: state, command, LED, cooldown
//   cfg       sink       register write: index 0 autostop enable, 1 limit
//
// A poll is captured in the input register and evaluated there; its result
// is loaded into the output register once that register is empty or being
// taken. One poll per cycle is sustained while results are not stalled. A
// stalled result holds the output register; the input register takes one
// more poll and then holds the input off until the result is taken.
// Reset returns all sequencer state and both configuration registers to
// their reset values. Configuration writes are always taken.
`default_nettype none

module autostart_mode_sequencer (
  input wire logic     clk,
  input wire logic     rst,
  asq_poll_if.sink     poll,
  asq_result_if.source result,
  asq_cfg_if.sink      cfg
);
  import asq_pkg::*;

  logic      s1_valid;
  poll_t     s1_item;
  logic      out_valid;
  result_t   out_item;
  logic      advance;
  result_t   step_res;
  cfg_regs_t cfg_regs;

  assign advance    = s1_valid && (!out_valid || result.ready);
  assign poll.ready = !s1_valid || advance;
  assign cfg.ready  = 1'b1;

  assign result.valid = out_valid;
  assign result.item  = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (poll.ready) begin
      s1_valid <= poll.valid;
    end
    if (poll.valid && poll.ready) begin
      s1_item <= poll.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || result.ready) begin
      out_valid <= s1_valid;
    end
    if (advance) begin
      out_item <= step_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        REG_AUTOSTOP_ENABLE: cfg_regs.autostop_enable <= cfg.wdata[0];
        REG_COOLDOWN_LIMIT:  cfg_regs.cooldown_limit  <= cfg.wdata;
        default: ;
      endcase
    end
  end

  asq_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .poll (s1_item),
    .cfg  (cfg_regs),
    .res  (step_res)
  );

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for autostart_mode_sequencer: directed polls, then random sessions.
// It predicts each poll's outcome and compares results field by field.
// Depends on asq_pkg, asq_ifs and the RTL of the sequencer.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import asq_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD = 80;

  // Tracks the sequencer state and holds the outcomes of accepted polls until they return.
  class autostart_scoreboard;
    result_t   outcomes_due[$];
    int        errors;
    logic      autostop_en;
    logic [15:0] stop_limit;
    as_state_t seq_state;
    logic [31:0] cooldown_start;
    cmd_t      cmd_sent;
    logic [7:0]  resend_count;
    logic [31:0] tick_seen;
    logic [15:0] cooldown_ticks;

    function new();
      errors = 0;
      autostop_en = 1'b0;
      stop_limit = '0;
      seq_state = ST_IDLE;
      cooldown_start = '0;
      cmd_sent = CMD_NONE;
      resend_count = KEEPALIVE_TICKS;
      tick_seen = '0;
      cooldown_ticks = '0;
    endfunction

    function void write_reg(logic idx, logic [15:0] data);
      if (idx == REG_AUTOSTOP_ENABLE) autostop_en = data[0];
      else stop_limit = data;
    endfunction

    function void note_poll(poll_t p);
      cmd_t        cmd;
      result_t     r;
      logic [31:0] span;
      cmd = CMD_NONE;
      r = '0;
      if (!p.auto_enable) begin
        seq_state = ST_IDLE;
      end else begin
        case (p.machine_mode)
          MODE_AUTOSTARTING: seq_state = ST_STARTUP;
          MODE_ENG_START, MODE_REV1, MODE_PUMP_UP, MODE_INLET_CLOSE: seq_state = ST_STARTING;
          MODE_RUN_UNLOADED: begin
            cooldown_start = p.tick_now;
            seq_state = ST_RUNNING;
          end
          MODE_REV2: seq_state = ST_LOADED;
          MODE_PRE_LOADED, MODE_LOADED_LO, MODE_LOADED_HI: begin
            if (seq_state != ST_COOLDOWN) seq_state = ST_LOADED;
          end
          MODE_DOWN: begin
            seq_state = ST_ERROR;
            r.red_led_set = 1'b1;
          end
          default: begin
            seq_state = ST_STOPPED;
            if (p.start_switch) cmd = CMD_START;
          end
        endcase
      end

      if (seq_state == ST_LOADED) begin
        if (!p.start_switch && autostop_en) begin
          cooldown_start = p.tick_now;
          seq_state = ST_COOLDOWN;
        end
      end else if (seq_state == ST_COOLDOWN) begin
        if (p.start_switch) begin
          seq_state = ST_LOADED;
        end else begin
          span = p.tick_now - cooldown_start;
          cooldown_ticks = span[15:0];
          if (cooldown_ticks >= stop_limit) cmd = CMD_STOP;
        end
      end

      // An unchanged command only counts down toward a keepalive resend.
      if (cmd == cmd_sent && resend_count != 0) begin
        if (tick_seen != p.tick_now) begin
          tick_seen = p.tick_now;
          resend_count = resend_count - 8'd1;
        end
      end else if (p.sender_idle) begin
        resend_count = KEEPALIVE_TICKS;
        cmd_sent = cmd;
        r.send_now = 1'b1;
        r.command_code = cmd;
      end

      r.autostart_state = seq_state;
      r.cooldown_elapsed = cooldown_ticks;
      outcomes_due.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_outcome(result_t got);
      result_t want;
      if (outcomes_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = outcomes_due.pop_front();
      compare_field("autostart_state", 32'(want.autostart_state), 32'(got.autostart_state));
      compare_field("send_now", 32'(want.send_now), 32'(got.send_now));
      compare_field("command_code", 32'(want.command_code), 32'(got.command_code));
      compare_field("red_led_set", 32'(want.red_led_set), 32'(got.red_led_set));
      compare_field("cooldown_elapsed", 32'(want.cooldown_elapsed),
                    32'(got.cooldown_elapsed));
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   reset_done;
  bit   poll_gaps_on = 1'b1;
  bit   result_gaps_on = 1'b1;
  int   polls_sent;
  int   idle_cycles = 0;
  logic [31:0] tick_cnt;
  autostart_scoreboard sb = new();

  asq_poll_if   poll_ch();
  asq_result_if result_ch();
  asq_cfg_if    cfg_ch();

  autostart_mode_sequencer u_top (
    .clk    (clk),
    .rst    (rst),
    .poll   (poll_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((poll_ch.valid && poll_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog, no transaction for %0d cycles", $time, idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stalls, with a long hold now and then so the block backs up.
  initial begin
    int gap;
    int results_seen;
    results_seen = 0;
    result_ch.ready <= 1'b0;
    wait (reset_done);
    forever begin
      gap = result_gaps_on ? $urandom_range(0, 15) : 0;
      if (results_seen % 400 == 150) gap = LONG_HOLD;
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
      sb.check_outcome(result_ch.item);
      results_seen++;
      if (results_seen % 64 == 0) result_gaps_on = 1'($urandom_range(0, 1));
    end
  end

  function automatic poll_t mk_poll(logic a, logic sw, logic [3:0] mode, logic [31:0] tick,
                                    logic idle);
    poll_t p;
    p.auto_enable = a;
    p.start_switch = sw;
    p.machine_mode = mode;
    p.tick_now = tick;
    p.sender_idle = idle;
    return p;
  endfunction

  // Mostly small steps like a free-running counter, with jumps so every bit moves.
  function automatic logic [31:0] next_tick(logic [31:0] t);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return t + $urandom_range(0, 3);
    if (r < 92) return t + $urandom_range(0, 2000);
    if (r < 97) return t + $urandom_range(60000, 70000);
    return $urandom();
  endfunction

  // Valid stays high across back-to-back transactions; it only drops for a gap.
  task automatic send_poll(poll_t p);
    int gap;
    gap = poll_gaps_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      poll_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    poll_ch.valid <= 1'b1;
    poll_ch.item <= p;
    @(posedge clk);
    while (!poll_ch.ready) @(posedge clk);
    sb.note_poll(p);
    polls_sent++;
    if (polls_sent % 64 == 0) poll_gaps_on = 1'($urandom_range(0, 1));
  endtask

  task automatic issue_poll(logic a, logic sw, logic [3:0] mode);
    tick_cnt = next_tick(tick_cnt);
    send_poll(mk_poll(a, sw, mode, tick_cnt, $urandom_range(0, 99) < 85));
  endtask

  function automatic logic auto_on();
    return $urandom_range(0, 99) < 98;
  endfunction

  task automatic write_config(logic en, logic [15:0] limit);
    cfg_ch.valid <= 1'b1;
    cfg_ch.reg_index <= REG_AUTOSTOP_ENABLE;
    cfg_ch.wdata <= {15'd0, en};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.write_reg(REG_AUTOSTOP_ENABLE, {15'd0, en});
    cfg_ch.reg_index <= REG_COOLDOWN_LIMIT;
    cfg_ch.wdata <= limit;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.write_reg(REG_COOLDOWN_LIMIT, limit);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_for_results();
    poll_ch.valid <= 1'b0;
    while (sb.outcomes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One machine run: start-up, run, a loaded stretch at times long enough for cooldown and
  // keepalive resends, then sometimes a fault or stop. Some sessions are plain noise.
  task automatic run_session();
    int n;
    if ($urandom_range(0, 99) < 15) begin
      n = $urandom_range(1, 20);
      repeat (n) begin
        issue_poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   4'($urandom_range(0, 15)));
      end
    end else begin
      n = $urandom_range(0, 3);
      repeat (n) issue_poll(auto_on(), 1'($urandom_range(0, 1)), MODE_AUTOSTARTING);
      n = $urandom_range(0, 6);
      repeat (n) issue_poll(auto_on(), 1'($urandom_range(0, 1)), 4'($urandom_range(1, 4)));
      n = $urandom_range(1, 5);
      repeat (n) issue_poll(auto_on(), 1'($urandom_range(0, 1)), MODE_RUN_UNLOADED);
      n = $urandom_range(5, 260);
      repeat (n) begin
        issue_poll(auto_on(), $urandom_range(0, 99) < 8,
                   ($urandom_range(0, 99) < 20) ? MODE_REV2 : 4'($urandom_range(7, 9)));
      end
      case ($urandom_range(0, 3))
        0: begin
          n = $urandom_range(1, 5);
          repeat (n) issue_poll(auto_on(), 1'($urandom_range(0, 1)), MODE_DOWN);
        end
        1: begin
          n = $urandom_range(1, 8);
          repeat (n) begin
            issue_poll(auto_on(), 1'($urandom_range(0, 1)), 4'($urandom_range(11, 15)));
          end
        end
        default: ;
      endcase
    end
  endtask

  task automatic run_phase(logic en, logic [15:0] limit, int count);
    int target;
    write_config(en, limit);
    target = polls_sent + count;
    while (polls_sent < target) run_session();
    wait_for_results();
  endtask

  initial begin
    rst <= 1'b1;
    poll_ch.valid <= 1'b0;
    poll_ch.item <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.reg_index <= REG_AUTOSTOP_ENABLE;
    cfg_ch.wdata <= '0;
    polls_sent = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    reset_done = 1'b1;

    write_config(1'b1, 16'hFFFF);
    send_poll(mk_poll(1'b0, 1'b1, 4'd15, 32'hFFFF_FFFF, 1'b1));
    send_poll(mk_poll(1'b1, 1'b0, MODE_AUTOSTARTING, 32'h0, 1'b1));
    send_poll(mk_poll(1'b1, 1'b1, MODE_ENG_START, 32'h1, 1'b1));
    send_poll(mk_poll(1'b1, 1'b0, MODE_REV1, 32'h2, 1'b1));
    send_poll(mk_poll(1'b1, 1'b1, MODE_PUMP_UP, 32'h3, 1'b1));
    send_poll(mk_poll(1'b1, 1'b0, MODE_INLET_CLOSE, 32'h4, 1'b1));
    send_poll(mk_poll(1'b1, 1'b0, MODE_RUN_UNLOADED, 32'hFFFF_FFF0, 1'b1));
    // Enter cooldown just below the 32-bit wrap, then reach the full 16-bit limit.
    send_poll(mk_poll(1'b1, 1'b0, MODE_PRE_LOADED, 32'hFFFF_FFF2, 1'b1));
    send_poll(mk_poll(1'b1, 1'b0, MODE_LOADED_LO, 32'hFFFF_FFF7, 1'b1));
    // The stop is due but the buffer is busy, so it is retried on the next poll.
    send_poll(mk_poll(1'b1, 1'b0, MODE_LOADED_HI, 32'h0000_FFF1, 1'b0));
    send_poll(mk_poll(1'b1, 1'b0, MODE_LOADED_HI, 32'h0000_FFF1, 1'b1));
    // Rev2 during cooldown forces loaded and re-enters cooldown on the same poll.
    send_poll(mk_poll(1'b1, 1'b0, MODE_REV2, 32'h0000_FFF4, 1'b1));
    send_poll(mk_poll(1'b1, 1'b1, MODE_LOADED_LO, 32'h0000_FFF5, 1'b1));
    send_poll(mk_poll(1'b1, 1'b0, MODE_LOADED_LO, 32'h0000_FFF6, 1'b1));
    send_poll(mk_poll(1'b1, 1'b0, MODE_DOWN, 32'h0001_0000, 1'b1));
    send_poll(mk_poll(1'b1, 1'b1, MODE_OTHER, 32'h0001_0001, 1'b0));
    send_poll(mk_poll(1'b1, 1'b1, MODE_OTHER, 32'h0001_0002, 1'b1));
    send_poll(mk_poll(1'b1, 1'b0, 4'd12, 32'h8000_0000, 1'b1));
    send_poll(mk_poll(1'b1, 1'b1, 4'd13, 32'h7FFF_FFFF, 1'b1));
    send_poll(mk_poll(1'b1, 1'b0, 4'd14, 32'hAAAA_5555, 1'b0));
    send_poll(mk_poll(1'b1, 1'b1, 4'd15, 32'h0, 1'b1));
    send_poll(mk_poll(1'b0, 1'b0, MODE_AUTOSTARTING, 32'h5555_AAAA, 1'b1));
    tick_cnt = 32'h5555_AAAA;
    wait_for_results();

    run_phase(1'b0, 16'd0, 160);
    run_phase(1'b1, 16'd0, 160);
    run_phase(1'b1, 16'hFFFF, 160);
    run_phase(1'b1, 16'($urandom_range(1, 300)), 160);
    run_phase(1'b1, 16'($urandom_range(0, 65535)), 160);
    run_phase(1'b0, 16'($urandom_range(0, 65535)), 160);
    run_phase(1'b1, 16'($urandom_range(1, 60)), 160);

    if (sb.errors == 0 && sb.outcomes_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
